>>> rtl/spc_pkg.sv
// Shared types, constants and fixed-point helpers for the sphere pair contact block.
// No dependencies; used by spc_iter and sphere_pair_contact.
`default_nettype none
package spc_pkg;

    localparam int CW = 20;          // component width
    localparam int FB = 10;          // fraction bits
    localparam int BW = 12;          // restitution width
    localparam int VW = 3 * CW;      // packed vector width
    localparam int PW = 57;          // product width of the shared multiplier
    localparam int ROOT_STEPS = 21;
    localparam int DIV_STEPS = 32;

    localparam logic signed [CW-1:0] LIMIT_RESET = -20'sd1024;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIST,
        S_ROOT,
        S_NDIV,
        S_PROJ,
        S_FIN,
        S_MASS,
        S_MDIV,
        S_VDOT,
        S_BIAS,
        S_OUT
    } state_t;

    typedef struct packed {
        logic start;
        logic root_mode;
    } iter_req_t;

    function automatic logic signed [CW-1:0] get_comp(input logic [VW-1:0] v,
                                                      input logic [1:0] i);
        logic signed [CW-1:0] r;
        case (i)
            2'd0:    r = v[CW-1:0];
            2'd1:    r = v[2*CW-1:CW];
            default: r = v[3*CW-1:2*CW];
        endcase
        return r;
    endfunction

    // add half an LSB, then arithmetic shift: nearest, ties toward +inf
    function automatic logic signed [PW-1:0] round_shift(input logic signed [PW-1:0] v);
        logic signed [PW-1:0] t;
        t = v + (PW'(1) <<< (FB - 1));
        return t >>> FB;
    endfunction

    function automatic logic signed [CW-1:0] sat_comp(input logic signed [PW-1:0] v);
        logic signed [PW-1:0] hi;
        logic signed [PW-1:0] lo;
        logic signed [CW-1:0] r;
        hi = (PW'(1) <<< (CW - 1)) - PW'(1);
        lo = -hi - PW'(1);
        if (v > hi) begin
            r = hi[CW-1:0];
        end else if (v < lo) begin
            r = lo[CW-1:0];
        end else begin
            r = v[CW-1:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

>>> rtl/spc_iter.sv
// Shared iterative unit: restoring square root (2 bits a step) or division (1 bit a step).
// Depends on spc_pkg for the request struct and step counts.
`default_nettype none
module spc_iter (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  spc_pkg::iter_req_t   req,
    input  wire  [41:0]          radicand,
    input  wire  [31:0]          numer,
    input  wire  [21:0]          divisor,
    output logic                 done,
    output logic [31:0]          result
);

    logic        busy_reg;
    logic        root_reg;
    logic        done_reg;
    logic [5:0]  cnt_reg;
    logic [41:0] src_reg;
    logic [23:0] rem_reg;
    logic [31:0] res_reg;
    logic [21:0] div_reg;

    logic [23:0] rem_shift;
    logic [23:0] trial;
    logic [24:0] diff;
    logic        ge;

    always_comb begin
        if (root_reg) begin
            rem_shift = {rem_reg[21:0], src_reg[41:40]};
            trial     = {res_reg[21:0], 2'b01};
        end else begin
            rem_shift = {rem_reg[22:0], src_reg[41]};
            trial     = {2'b00, div_reg};
        end
        diff = {1'b0, rem_shift} - {1'b0, trial};
        ge   = ~diff[24];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == 6'd1) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            root_reg <= req.root_mode;
            cnt_reg  <= req.root_mode ? 6'(spc_pkg::ROOT_STEPS) : 6'(spc_pkg::DIV_STEPS);
            src_reg  <= req.root_mode ? radicand : {numer, 10'b0};
            rem_reg  <= '0;
            res_reg  <= '0;
            div_reg  <= divisor;
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[23:0] : rem_shift;
            res_reg <= {res_reg[30:0], ge};
            src_reg <= root_reg ? {src_reg[39:0], 2'b00} : {src_reg[40:0], 1'b0};
            cnt_reg <= cnt_reg - 6'd1;
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule
`default_nettype wire

>>> rtl/sphere_pair_contact.sv
// Sphere pair contact: one pair of spheres in, one contact result out; uses spc_pkg and spc_iter.
// Steps from request to result: distance; for an overlapping pair root, normal division (skipped
// for coincident centres), projection; always mass division unless both inverse masses are zero.
// One pair at a time: a new pair is taken only after the result handshake and idle; root and all
// divisions run on the shared iterative unit, all products on one shared 34x23 multiplier.
// Reset (aresetn low, synchronous) clears the held contact, sets the limit to -1.0, empties output.
`default_nettype none
module sphere_pair_contact (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          s_tvalid,
    output logic         s_tready,
    // centre_a, centre_b, radius_a, radius_b, velocity_a, velocity_b,
    // inv_mass_a, inv_mass_b, bounce_a, bounce_b (from bit 0 up)
    input  wire  [343:0] s_tdata,
    output logic         m_tvalid,
    input  wire          m_tready,
    // unit_normal, surface_point_a, surface_point_b, contact_midpoint,
    // penetration, effective_mass, bias_speed, 4 zero bits (from bit 0 up)
    output logic [303:0] m_tdata,
    // overlapping, coincident (from bit 0 up)
    output logic [1:0]   m_tuser,
    input  wire          cfg_valid,
    output logic         cfg_ready,
    input  wire  [19:0]  cfg_data
);

    localparam int PW = spc_pkg::PW;

    spc_pkg::state_t state_reg, state_next;
    logic        phase_reg;
    logic [1:0]  comp_reg;
    logic [1:0]  term_reg;
    logic        hit_reg;
    logic        same_reg;
    logic signed [19:0] limit_reg;

    logic [343:0] in_reg;
    logic [41:0]  dist2_reg;
    logic [20:0]  dist_reg;
    logic signed [19:0] n_reg  [3];
    logic signed [19:0] pa_reg [3];
    logic signed [19:0] pb_reg [3];
    logic signed [43:0] acc_reg;
    logic signed [PW-1:0] prod_reg;
    logic [19:0]  emass_reg;
    logic signed [19:0] bias_reg;
    logic [59:0]  held_normal_reg;
    logic [59:0]  held_point_a_reg;
    logic [59:0]  held_point_b_reg;
    logic [59:0]  held_mid_reg;
    logic signed [19:0] held_sep_reg;

    logic [59:0] centre_a, centre_b, vel_a, vel_b;
    logic [19:0] ra, rb, ka, kb;
    logic [11:0] ea, eb, e_max;
    logic [20:0] rsum;
    logic [20:0] k_sum;
    logic signed [20:0] d_w  [3];
    logic signed [20:0] dv_w [3];
    logic signed [20:0] d_sel;
    logic [19:0]  mag;
    logic signed [PW-1:0] sr_prod;
    logic signed [PW-1:0] vrel_w;
    logic         apply_bias;
    logic signed [33:0] mul_a;
    logic signed [22:0] mul_b;

    spc_pkg::iter_req_t iter_req;
    logic [31:0] iter_numer;
    logic [21:0] iter_div;
    logic        iter_done;
    logic [31:0] iter_res;
    logic        hit_now;

    assign centre_a = in_reg[59:0];
    assign centre_b = in_reg[119:60];
    assign ra       = in_reg[139:120];
    assign rb       = in_reg[159:140];
    assign vel_a    = in_reg[219:160];
    assign vel_b    = in_reg[279:220];
    assign ka       = in_reg[299:280];
    assign kb       = in_reg[319:300];
    assign ea       = in_reg[331:320];
    assign eb       = in_reg[343:332];
    assign rsum     = {1'b0, ra} + {1'b0, rb};
    assign k_sum    = {1'b0, ka} + {1'b0, kb};
    assign e_max    = (ea > eb) ? ea : eb;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            d_w[i]  = 21'(spc_pkg::get_comp(centre_b, 2'(i)))
                    - 21'(spc_pkg::get_comp(centre_a, 2'(i)));
            dv_w[i] = 21'(spc_pkg::get_comp(vel_b, 2'(i)))
                    - 21'(spc_pkg::get_comp(vel_a, 2'(i)));
        end
    end

    assign d_sel   = (comp_reg == 2'd3) ? 21'sd0 : d_w[comp_reg];
    assign mag     = d_sel[20] ? 20'(-d_sel) : d_sel[19:0];
    assign sr_prod = spc_pkg::round_shift(prod_reg);
    assign vrel_w  = spc_pkg::round_shift(PW'(acc_reg));
    assign apply_bias = vrel_w < PW'(limit_reg);
    assign hit_now = dist2_reg < prod_reg[41:0];

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            spc_pkg::S_DIST: begin
                if (comp_reg == 2'd3) begin
                    mul_a = $signed({13'b0, rsum});
                    mul_b = $signed({2'b0, rsum});
                end else begin
                    mul_a = 34'(d_sel);
                    mul_b = 23'(d_sel);
                end
            end
            spc_pkg::S_PROJ: begin
                case (term_reg)
                    2'd0: begin
                        mul_a = 34'(n_reg[comp_reg]);
                        mul_b = $signed({3'b0, ra});
                    end
                    2'd1: begin
                        mul_a = 34'(n_reg[comp_reg]);
                        mul_b = $signed({3'b0, rb});
                    end
                    default: begin
                        mul_a = 34'(d_sel);
                        mul_b = 23'(n_reg[comp_reg]);
                    end
                endcase
            end
            spc_pkg::S_VDOT: begin
                mul_a = 34'((comp_reg == 2'd3) ? 21'sd0 : dv_w[comp_reg]);
                mul_b = 23'(spc_pkg::get_comp(held_normal_reg, comp_reg));
            end
            spc_pkg::S_BIAS: begin
                mul_a = -vrel_w[33:0];
                mul_b = $signed({11'b0, e_max});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= PW'(mul_a) * PW'(mul_b);
    end

    // iterative unit requests
    always_comb begin
        iter_req.start     = 1'b0;
        iter_req.root_mode = (state_reg == spc_pkg::S_ROOT);
        iter_numer         = '0;
        iter_div           = '0;
        case (state_reg)
            spc_pkg::S_ROOT: iter_req.start = !phase_reg;
            spc_pkg::S_NDIV: begin
                iter_req.start = !phase_reg;
                iter_numer     = {2'b0, mag, 10'b0} + {12'b0, dist_reg[20:1]};
                iter_div       = {1'b0, dist_reg};
            end
            spc_pkg::S_MDIV: begin
                iter_req.start = !phase_reg;
                iter_numer     = (32'd1 << (2 * spc_pkg::FB)) + {12'b0, k_sum[20:1]};
                iter_div       = {1'b0, k_sum};
            end
            default: iter_req.start = 1'b0;
        endcase
    end

    spc_iter u_iter (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (iter_req),
        .radicand (dist2_reg),
        .numer    (iter_numer),
        .divisor  (iter_div),
        .done     (iter_done),
        .result   (iter_res)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            spc_pkg::S_IDLE: if (s_tvalid) state_next = spc_pkg::S_DIST;
            spc_pkg::S_DIST: begin
                if (phase_reg && comp_reg == 2'd3) begin
                    state_next = hit_now ? spc_pkg::S_ROOT : spc_pkg::S_MASS;
                end
            end
            spc_pkg::S_ROOT: begin
                if (iter_done) state_next = same_reg ? spc_pkg::S_PROJ : spc_pkg::S_NDIV;
            end
            spc_pkg::S_NDIV: if (iter_done && comp_reg == 2'd2) state_next = spc_pkg::S_PROJ;
            spc_pkg::S_PROJ: begin
                if (phase_reg && comp_reg == 2'd2 && term_reg == 2'd2) begin
                    state_next = spc_pkg::S_FIN;
                end
            end
            spc_pkg::S_FIN:  state_next = spc_pkg::S_MASS;
            spc_pkg::S_MASS: state_next = (k_sum != 21'd0) ? spc_pkg::S_MDIV : spc_pkg::S_VDOT;
            spc_pkg::S_MDIV: if (iter_done) state_next = spc_pkg::S_VDOT;
            spc_pkg::S_VDOT: if (phase_reg && comp_reg == 2'd2) state_next = spc_pkg::S_BIAS;
            spc_pkg::S_BIAS: if (phase_reg) state_next = spc_pkg::S_OUT;
            spc_pkg::S_OUT:  if (m_tready) state_next = spc_pkg::S_IDLE;
            default:         state_next = spc_pkg::S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= spc_pkg::S_IDLE;
            phase_reg        <= 1'b0;
            comp_reg         <= '0;
            term_reg         <= '0;
            hit_reg          <= 1'b0;
            same_reg         <= 1'b0;
            limit_reg        <= spc_pkg::LIMIT_RESET;
            held_normal_reg  <= '0;
            held_point_a_reg <= '0;
            held_point_b_reg <= '0;
            held_mid_reg     <= '0;
            held_sep_reg     <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) limit_reg <= cfg_data;
            case (state_reg)
                spc_pkg::S_IDLE: begin
                    phase_reg <= 1'b0;
                    comp_reg  <= '0;
                    term_reg  <= '0;
                end
                spc_pkg::S_DIST: begin
                    phase_reg <= !phase_reg;
                    if (phase_reg) begin
                        comp_reg <= comp_reg + 2'd1;
                        if (comp_reg == 2'd3) begin
                            hit_reg  <= hit_now;
                            same_reg <= hit_now && (dist2_reg == 42'd0);
                            comp_reg <= '0;
                        end
                    end
                end
                spc_pkg::S_ROOT, spc_pkg::S_NDIV, spc_pkg::S_MDIV: begin
                    if (!phase_reg) begin
                        phase_reg <= 1'b1;
                    end else if (iter_done) begin
                        phase_reg <= 1'b0;
                        comp_reg  <= (state_reg == spc_pkg::S_NDIV) ? comp_reg + 2'd1 : 2'd0;
                        if (state_reg == spc_pkg::S_NDIV && comp_reg == 2'd2) begin
                            comp_reg <= '0;
                        end
                    end
                end
                spc_pkg::S_PROJ: begin
                    phase_reg <= !phase_reg;
                    if (phase_reg) begin
                        if (term_reg == 2'd2) begin
                            term_reg <= '0;
                            comp_reg <= (comp_reg == 2'd2) ? 2'd0 : comp_reg + 2'd1;
                        end else begin
                            term_reg <= term_reg + 2'd1;
                        end
                    end
                end
                spc_pkg::S_FIN: begin
                    for (int i = 0; i < 3; i++) begin
                        held_normal_reg[i*20 +: 20]  <= n_reg[i];
                        held_point_a_reg[i*20 +: 20] <= pa_reg[i];
                        held_point_b_reg[i*20 +: 20] <= pb_reg[i];
                        held_mid_reg[i*20 +: 20]     <=
                            20'((21'(pa_reg[i]) + 21'(pb_reg[i])) >>> 1);
                    end
                    held_sep_reg <= spc_pkg::sat_comp(
                        spc_pkg::round_shift(PW'(acc_reg)) - PW'({1'b0, ra}) - PW'({1'b0, rb}));
                end
                spc_pkg::S_MASS: begin
                    phase_reg <= 1'b0;
                    comp_reg  <= '0;
                end
                spc_pkg::S_VDOT: begin
                    phase_reg <= !phase_reg;
                    if (phase_reg) comp_reg <= (comp_reg == 2'd2) ? 2'd0 : comp_reg + 2'd1;
                end
                spc_pkg::S_BIAS: phase_reg <= !phase_reg;
                default: phase_reg <= 1'b0;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            spc_pkg::S_IDLE: begin
                if (s_tvalid) in_reg <= s_tdata;
                dist2_reg <= '0;
            end
            spc_pkg::S_DIST: begin
                if (phase_reg && comp_reg != 2'd3) dist2_reg <= dist2_reg + prod_reg[41:0];
            end
            spc_pkg::S_ROOT: begin
                acc_reg <= '0;
                if (iter_done) begin
                    dist_reg <= iter_res[20:0];
                    if (same_reg) begin
                        for (int i = 0; i < 3; i++) n_reg[i] <= '0;
                    end
                end
            end
            spc_pkg::S_NDIV: begin
                if (iter_done && comp_reg != 2'd3) begin
                    if (d_sel[20]) begin
                        n_reg[comp_reg] <= (iter_res > 32'd524288) ? -20'sd524288
                                                                   : 20'(-iter_res);
                    end else begin
                        n_reg[comp_reg] <= (iter_res > 32'd524287) ? 20'sd524287
                                                                   : iter_res[19:0];
                    end
                end
            end
            spc_pkg::S_PROJ: begin
                if (phase_reg && comp_reg != 2'd3) begin
                    case (term_reg)
                        2'd0: pa_reg[comp_reg] <= spc_pkg::sat_comp(
                            PW'(spc_pkg::get_comp(centre_a, comp_reg)) + sr_prod);
                        2'd1: pb_reg[comp_reg] <= spc_pkg::sat_comp(
                            PW'(spc_pkg::get_comp(centre_b, comp_reg)) - sr_prod);
                        default: acc_reg <= acc_reg + prod_reg[43:0];
                    endcase
                end
            end
            spc_pkg::S_MASS: begin
                emass_reg <= '0;
                acc_reg   <= '0;
            end
            spc_pkg::S_MDIV: begin
                if (iter_done) emass_reg <= (iter_res > 32'hFFFFF) ? 20'hFFFFF : iter_res[19:0];
            end
            spc_pkg::S_VDOT: begin
                if (phase_reg) acc_reg <= acc_reg + prod_reg[43:0];
            end
            spc_pkg::S_BIAS: begin
                if (phase_reg) bias_reg <= apply_bias ? spc_pkg::sat_comp(sr_prod) : 20'sd0;
            end
            default: begin
                dist2_reg <= dist2_reg;
            end
        endcase
    end

    assign s_tready  = (state_reg == spc_pkg::S_IDLE);
    assign m_tvalid  = (state_reg == spc_pkg::S_OUT);
    assign cfg_ready = 1'b1;
    assign m_tuser   = {same_reg, hit_reg};
    assign m_tdata   = {4'b0, bias_reg, emass_reg, held_sep_reg, held_mid_reg,
                        held_point_b_reg, held_point_a_reg, held_normal_reg};

`ifndef ASSERT_OFF
    a_no_accept_while_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input accepted while result pending");
    a_coincident_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1]) |-> m_tuser[0])
        else $error("coincident without overlap");
    a_done_in_iter_state: assert property (@(posedge aclk) disable iff (!aresetn)
        iter_done |-> (state_reg == spc_pkg::S_ROOT || state_reg == spc_pkg::S_NDIV
                       || state_reg == spc_pkg::S_MDIV))
        else $error("iterative unit finished outside its states");
`endif

endmodule
`default_nettype wire

>>> tb/sphere_pair_contact_test.sv
`timescale 1ns / 100ps
// Self-checking bench for sphere_pair_contact: stream sphere pairs in, predict each contact result.
// Depends on spc_pkg and the sphere_pair_contact RTL; nothing else.
module sphere_pair_contact_test;

    localparam int WATCHDOG_CYCLES = 2000;
    localparam int DRAIN_CYCLES = 250;
    localparam longint COMP_MAX = 524287;
    localparam longint COMP_MIN = -524288;

    typedef struct {
        logic [spc_pkg::VW-1:0] centre_a, centre_b, velocity_a, velocity_b;
        logic [spc_pkg::CW-1:0] radius_a, radius_b, inv_mass_a, inv_mass_b;
        logic [spc_pkg::BW-1:0] bounce_a, bounce_b;
    } pair_t;

    typedef struct {
        logic                   overlapping, coincident;
        logic [spc_pkg::VW-1:0] normal, point_a, point_b, midpoint;
        logic [spc_pkg::CW-1:0] penetration, eff_mass, bias;
    } contact_t;

    function automatic longint clamp(longint v);
        return v > COMP_MAX ? COMP_MAX : (v < COMP_MIN ? COMP_MIN : v);
    endfunction

    // nearest, ties toward +inf
    function automatic longint round_q(longint v);
        return (v + 512) >>> spc_pkg::FB;
    endfunction

    function automatic longint comp_of(logic [spc_pkg::VW-1:0] v, int i);
        logic signed [spc_pkg::CW-1:0] c;
        c = v[i*spc_pkg::CW +: spc_pkg::CW];
        return longint'(c);
    endfunction

    function automatic logic [spc_pkg::VW-1:0] pack_vec(longint x, longint y, longint z);
        logic [spc_pkg::CW-1:0] cx, cy, cz;
        cx = spc_pkg::CW'(clamp(x));
        cy = spc_pkg::CW'(clamp(y));
        cz = spc_pkg::CW'(clamp(z));
        return {cz, cy, cx};
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res, step;
        res = 0;
        step = 64'd1 << 62;
        while (step > v) step >>= 2;
        while (step != 0) begin
            if (v >= res + step) begin
                v -= res + step;
                res = (res >> 1) + step;
            end else begin
                res >>= 1;
            end
            step >>= 2;
        end
        return res;
    endfunction

    class contact_scoreboard;
        longint                 limit;
        logic [spc_pkg::VW-1:0] held_normal, held_pa, held_pb, held_mid;
        longint                 held_sep;
        contact_t               pending[$];
        int                     errors, results, hits, coincidents, biased;

        function new();
            limit = longint'(spc_pkg::LIMIT_RESET);
            held_normal = '0;
            held_pa = '0;
            held_pb = '0;
            held_mid = '0;
            held_sep = 0;
            errors = 0;
            results = 0;
            hits = 0;
            coincidents = 0;
            biased = 0;
        endfunction

        function void set_limit(logic [spc_pkg::CW-1:0] v);
            logic signed [spc_pkg::CW-1:0] s;
            s = v;
            limit = longint'(s);
        endfunction

        function void note_pair(pair_t p);
            longint a[3], b[3], d[3], n[3], pa[3], pb[3], mid[3];
            longint ra, rb, dist2, rsum, root_dist, mag, q, acc, vrel, k, emass, bias, e;
            contact_t r;
            ra = longint'(p.radius_a);
            rb = longint'(p.radius_b);
            dist2 = 0;
            for (int i = 0; i < 3; i++) begin
                a[i] = comp_of(p.centre_a, i);
                b[i] = comp_of(p.centre_b, i);
                d[i] = b[i] - a[i];
                dist2 += d[i] * d[i];
            end
            rsum = ra + rb;
            r.overlapping = dist2 < rsum * rsum;
            r.coincident = r.overlapping && dist2 == 0;
            if (r.overlapping) begin
                root_dist = int_sqrt(dist2);
                acc = 0;
                for (int i = 0; i < 3; i++) begin
                    if (r.coincident) begin
                        n[i] = 0;
                    end else begin
                        mag = d[i] < 0 ? -d[i] : d[i];
                        q = ((mag << spc_pkg::FB) + (root_dist >> 1)) / root_dist;
                        n[i] = clamp(d[i] < 0 ? -q : q);
                    end
                    pa[i] = clamp(a[i] + round_q(n[i] * ra));
                    pb[i] = clamp(b[i] - round_q(n[i] * rb));
                    mid[i] = (pa[i] + pb[i]) >>> 1;
                    acc += d[i] * n[i];
                end
                held_normal = pack_vec(n[0], n[1], n[2]);
                held_pa = pack_vec(pa[0], pa[1], pa[2]);
                held_pb = pack_vec(pb[0], pb[1], pb[2]);
                held_mid = pack_vec(mid[0], mid[1], mid[2]);
                held_sep = clamp(round_q(acc) - ra - rb);
            end
            k = longint'(p.inv_mass_a) + longint'(p.inv_mass_b);
            emass = 0;
            if (k != 0) begin
                emass = ((64'd1 << (2 * spc_pkg::FB)) + (k >> 1)) / k;
                if (emass > 1048575) emass = 1048575;
            end
            acc = 0;
            for (int i = 0; i < 3; i++)
                acc += comp_of(held_normal, i) *
                       (comp_of(p.velocity_b, i) - comp_of(p.velocity_a, i));
            vrel = round_q(acc);
            bias = 0;
            if (vrel < limit) begin
                e = p.bounce_a > p.bounce_b ? longint'(p.bounce_a) : longint'(p.bounce_b);
                bias = clamp(round_q(e * -vrel));
            end
            r.normal = held_normal;
            r.point_a = held_pa;
            r.point_b = held_pb;
            r.midpoint = held_mid;
            r.penetration = held_sep[spc_pkg::CW-1:0];
            r.eff_mass = emass[spc_pkg::CW-1:0];
            r.bias = bias[spc_pkg::CW-1:0];
            pending.push_back(r);
        endfunction

        function void compare(string name, logic [spc_pkg::VW-1:0] want,
                              logic [spc_pkg::VW-1:0] got);
            if (want !== got) begin
                $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_contact(logic [303:0] d, logic [1:0] u);
            contact_t w;
            if (pending.size() == 0) begin
                $display("%0t ns: unexpected contact result, expected none, actual %h", $time, d);
                errors++;
                return;
            end
            w = pending.pop_front();
            results++;
            hits += int'(w.overlapping);
            coincidents += int'(w.coincident);
            biased += int'(w.bias != 0);
            compare("overlapping", spc_pkg::VW'(w.overlapping), spc_pkg::VW'(u[0]));
            compare("coincident", spc_pkg::VW'(w.coincident), spc_pkg::VW'(u[1]));
            compare("unit_normal", w.normal, d[59:0]);
            compare("surface_point_a", w.point_a, d[119:60]);
            compare("surface_point_b", w.point_b, d[179:120]);
            compare("contact_midpoint", w.midpoint, d[239:180]);
            compare("penetration", spc_pkg::VW'(w.penetration), spc_pkg::VW'(d[259:240]));
            compare("effective_mass", spc_pkg::VW'(w.eff_mass), spc_pkg::VW'(d[279:260]));
            compare("bias_speed", spc_pkg::VW'(w.bias), spc_pkg::VW'(d[299:280]));
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn;
    logic s_tvalid, s_tready, m_tvalid, m_tready, cfg_valid, cfg_ready;
    logic [343:0] s_tdata;
    logic [303:0] m_tdata;
    logic [1:0] m_tuser;
    logic [19:0] cfg_data;

    contact_scoreboard contacts = new();
    int idle_cycles = 0;

    always #1 aclk = ~aclk;

    sphere_pair_contact dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_CYCLES) begin
            $display("%0t ns: watchdog expired with %0d results outstanding",
                     $time, contacts.pending.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic longint rand_span(longint lo, longint hi);
        return lo + longint'($urandom_range(0, 32'(hi - lo)));
    endfunction

    function automatic pair_t random_pair();
        pair_t p;
        longint ax, ay, az, span;
        int mode;
        mode = $urandom_range(0, 19);
        if (mode < 2) begin
            // raw bit noise
            p.centre_a = spc_pkg::VW'({$urandom, $urandom});
            p.centre_b = spc_pkg::VW'({$urandom, $urandom});
            p.velocity_a = spc_pkg::VW'({$urandom, $urandom});
            p.velocity_b = spc_pkg::VW'({$urandom, $urandom});
            p.radius_a = spc_pkg::CW'($urandom);
            p.radius_b = spc_pkg::CW'($urandom);
            p.inv_mass_a = spc_pkg::CW'($urandom);
            p.inv_mass_b = spc_pkg::CW'($urandom);
            p.bounce_a = spc_pkg::BW'($urandom);
            p.bounce_b = spc_pkg::BW'($urandom);
            return p;
        end
        span = (mode == 2) ? 524287 : 200000;
        ax = rand_span(-span, span);
        ay = rand_span(-span, span);
        az = rand_span(-span, span);
        p.centre_a = pack_vec(ax, ay, az);
        if (mode == 3) begin
            p.centre_b = p.centre_a;
        end else begin
            p.centre_b = pack_vec(ax + rand_span(-4096, 4096), ay + rand_span(-4096, 4096),
                                  az + rand_span(-4096, 4096));
        end
        p.radius_a = spc_pkg::CW'((mode == 2) ? $urandom : $urandom_range(0, 4096));
        p.radius_b = spc_pkg::CW'((mode == 2) ? $urandom : $urandom_range(0, 4096));
        p.velocity_a = pack_vec(rand_span(-8192, 8192), rand_span(-8192, 8192),
                                rand_span(-8192, 8192));
        p.velocity_b = pack_vec(rand_span(-8192, 8192), rand_span(-8192, 8192),
                                rand_span(-8192, 8192));
        p.inv_mass_a = ($urandom_range(0, 7) == 0) ? 20'd0 : 20'($urandom_range(0, 4096));
        p.inv_mass_b = ($urandom_range(0, 7) == 0) ? 20'd0 : 20'($urandom_range(0, 4096));
        p.bounce_a = spc_pkg::BW'($urandom_range(0, 2048));
        p.bounce_b = ($urandom_range(0, 9) == 0) ? 12'($urandom) : 12'($urandom_range(0, 2048));
        return p;
    endfunction

    function automatic pair_t quiet_pair(longint ax, longint bx, longint ra, longint rb);
        pair_t p;
        p.centre_a = pack_vec(ax, 0, 0);
        p.centre_b = pack_vec(bx, 0, 0);
        p.radius_a = spc_pkg::CW'(ra);
        p.radius_b = spc_pkg::CW'(rb);
        p.velocity_a = pack_vec(2048, 0, 0);
        p.velocity_b = pack_vec(-2048, 0, 0);
        p.inv_mass_a = 20'd1024;
        p.inv_mass_b = 20'd1024;
        p.bounce_a = 12'd512;
        p.bounce_b = 12'd256;
        return p;
    endfunction

    task automatic send_pair(pair_t p);
        int gap;
        gap = $urandom_range(0, 5);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {p.bounce_b, p.bounce_a, p.inv_mass_b, p.inv_mass_a, p.velocity_b,
                    p.velocity_a, p.radius_b, p.radius_a, p.centre_b, p.centre_a};
        do @(posedge aclk); while (!s_tready);
        contacts.note_pair(p);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (contacts.pending.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // hold the sender until every pair is answered, then update the limit
    task automatic write_limit(logic [19:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        contacts.set_limit(v);
    endtask

    initial begin
        int stall;
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            contacts.check_contact(m_tdata, m_tuser);
        end
    end

    initial begin
        pair_t p;
        logic [19:0] limits[4];
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        cfg_valid <= 1'b0;
        cfg_data <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: touching, apart, coincident, masses, restitution and saturation corners
        send_pair(quiet_pair(0, 0, 0, 0));
        send_pair(quiet_pair(0, 2048, 1024, 1024));
        send_pair(quiet_pair(0, 4096, 1024, 1024));
        send_pair(quiet_pair(0, 1536, 1024, 1024));
        send_pair(quiet_pair(100, 100, 1024, 0));
        p = quiet_pair(COMP_MIN, COMP_MAX, 1048575, 1048575);
        p.inv_mass_a = '0;
        p.inv_mass_b = '0;
        p.bounce_a = 12'hfff;
        send_pair(p);
        p = quiet_pair(COMP_MAX, COMP_MIN, 1048575, 1048575);
        p.inv_mass_a = 20'd1;
        p.inv_mass_b = '0;
        p.velocity_a = pack_vec(COMP_MIN, COMP_MAX, COMP_MIN);
        p.velocity_b = pack_vec(COMP_MAX, COMP_MIN, COMP_MAX);
        send_pair(p);
        p = quiet_pair(0, 512, 1048575, 0);
        p.inv_mass_a = 20'hfffff;
        p.inv_mass_b = 20'hfffff;
        p.velocity_a = pack_vec(COMP_MAX, COMP_MAX, COMP_MAX);
        p.velocity_b = pack_vec(COMP_MIN, COMP_MIN, COMP_MIN);
        p.bounce_b = 12'hfff;
        send_pair(p);
        p.centre_a = pack_vec(COMP_MAX, COMP_MAX, COMP_MAX);
        p.centre_b = pack_vec(COMP_MAX - 900, COMP_MAX - 3, COMP_MIN + 7);
        send_pair(p);
        p.centre_b = pack_vec(COMP_MAX - 900, COMP_MAX - 300, COMP_MAX - 77);
        p.bounce_a = '0;
        p.bounce_b = '0;
        send_pair(p);
        p = quiet_pair(-3000, -1000, 1500, 900);
        p.inv_mass_a = 20'd1;
        p.inv_mass_b = 20'd1;
        send_pair(p);
        send_pair(quiet_pair(0, 100000, 10, 10));
        for (int i = 0; i < 8; i++) send_pair(random_pair());

        limits[0] = 20'h80000;
        limits[1] = 20'h00000;
        limits[2] = 20'($urandom_range(0, 524288) * -1);
        limits[3] = 20'h7ffff;
        for (int ph = 0; ph < 4; ph++) begin
            write_limit(limits[ph]);
            for (int i = 0; i < 400; i++) send_pair(random_pair());
        end

        drain();
        $display("Checked %0d contacts: %0d overlapping, %0d coincident, %0d with bias,",
                 contacts.results, contacts.hits, contacts.coincidents, contacts.biased);
        $display("under the reset limit and four written limits from minimum to maximum.");
        if (contacts.errors == 0 && contacts.pending.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
